// ===== rtl/pose_bounds_collision_goal_check_macros.svh =====
// assertion macros used by the checker file
`ifndef POSE_BOUNDS_COLLISION_GOAL_CHECK_MACROS_SVH
`define POSE_BOUNDS_COLLISION_GOAL_CHECK_MACROS_SVH

// checked property, ignored while reset is high
`define PBC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("pbc check failed");

// checked property that also holds during reset
`define PBC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pbc check failed");

`endif

// ===== rtl/pbc_pkg.sv =====
// ----------------------------------------------------------------------------
// pbc_pkg
// shared types and constants of the pose bounds, collision and goal check
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int CW        = 24;
  localparam int STAGES    = 16;
  localparam int REG_W     = 2 * CW;
  localparam int IDX_W     = 3;
  localparam int ANG_W     = 34;   // cordic x, y, z in q30
  localparam int CRN_W     = 28;   // corner coordinates

  // angle constants in 2^-16 rad
  localparam int TWO_PI     = 411775;
  localparam int PI_U       = 205887;
  localparam int HALF_PI    = 102944;
  localparam int MOD_OFFSET = 21 * TWO_PI;   // makes any pitch non negative
  localparam int RECIP      = 10430;         // floor(2^32 / TWO_PI)
  localparam int GAIN_Q30   = 652032874;
  localparam int ANG_SHIFT  = 14;            // 2^-16 rad to q30

  typedef enum logic [IDX_W-1:0] {
    REG_BOX_SIZE      = 3'd0,
    REG_MARGIN        = 3'd1,
    REG_LIM_RET_LIFT  = 3'd2,
    REG_LIM_PITCH_LAT = 3'd3,
    REG_TOP_GOAL_MIN  = 3'd4,
    REG_PITCH_TOL     = 3'd5,
    REG_MODE          = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] ret;
    logic signed [CW-1:0] lift;
    logic                 in_bounds;
    logic                 goal_cond;
  } pose_meta_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837830;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/pose_bounds_collision_goal_check.sv =====
// ----------------------------------------------------------------------------
// pose_bounds_collision_goal_check
// streaming limit, collision and goal check of candidate box poses
// ----------------------------------------------------------------------------
// Takes one pose per clock unless every stage holds a pose and the output
// stalls, and returns one result per pose, in order. The work runs
// through a 27 stage pipeline: bounds and goal conditions, pitch reduction
// modulo 2*pi by reciprocal multiply (three stages), quadrant fold, one
// register per cordic iteration (16), sign fix, four corner products, rounding,
// corner placement, min/max and the strict overlap test. Each stage moves on
// when it is empty or the stage after it moves, so bubbles are squeezed out and
// the input stays ready while results wait until every stage holds a pose.
// Registers are meant to be static between transactions; the user must write
// them only while no pose is in flight, the block itself does not enforce it.
module pose_bounds_collision_goal_check (
  input  logic                         clk,
  input  logic                         rst,
  // cfg
  input  logic                         cfg_we,
  input  logic [pbc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [pbc_pkg::REG_W-1:0]    cfg_data,
  // pose in: retreat, lift, pitch, lateral (24 bits each, lowest first)
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [4*pbc_pkg::CW-1:0]     s_tdata,
  // result: within_bounds, detached, goal_met, zero pad
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata
);
  import pbc_pkg::*;

  localparam int ST_CORD0  = 4;
  localparam int ST_NEG    = ST_CORD0 + STAGES + 1;
  localparam int ST_PROD   = ST_NEG + 1;
  localparam int ST_RND    = ST_PROD + 1;
  localparam int ST_CORNER = ST_RND + 1;
  localparam int ST_MINMAX = ST_CORNER + 1;
  localparam int NSTG      = ST_MINMAX + 2;
  localparam int PW        = ANG_W + CW + 1;

  // configuration registers
  logic [REG_W-1:0] box_size, lim_rl, lim_pl, top_min;
  logic [CW-1:0]    margin;
  logic [CW-2:0]    pitch_tol;
  logic [2:0]       mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_size  <= '0;
      margin    <= '0;
      lim_rl    <= '0;
      lim_pl    <= '0;
      top_min   <= '0;
      pitch_tol <= '0;
      mode      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_SIZE:      box_size  <= cfg_data;
        REG_MARGIN:        margin    <= cfg_data[CW-1:0];
        REG_LIM_RET_LIFT:  lim_rl    <= cfg_data;
        REG_LIM_PITCH_LAT: lim_pl    <= cfg_data;
        REG_TOP_GOAL_MIN:  top_min   <= cfg_data;
        REG_PITCH_TOL:     pitch_tol <= cfg_data[CW-2:0];
        REG_MODE:          mode      <= cfg_data[2:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  logic pivot, free_motion, need_max;
  assign pivot       = mode[0];
  assign free_motion = mode[1];
  assign need_max    = mode[2];

  logic [CW-1:0] depth, height;
  assign depth  = box_size[CW-1:0];
  assign height = box_size[2*CW-1:CW];

  // per stage valid and move enable
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || m_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NSTG-1];

  // stage 0: input capture
  logic signed [CW-1:0] in_ret, in_lift, in_pitch, in_lat;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      in_ret   <= s_tdata[CW-1:0];
      in_lift  <= s_tdata[2*CW-1:CW];
      in_pitch <= s_tdata[3*CW-1:2*CW];
      in_lat   <= s_tdata[4*CW-1:3*CW];
    end
  end

  // stage 1: bounds, goal condition, quotient estimate of pitch / 2pi
  pose_meta_t meta [1:ST_MINMAX];
  logic [CW:0] u1, u2;
  logic [5:0]  q1;

  logic [CW-1:0]   lat_abs;
  logic            within_c, goal_c;
  logic [CW+1:0]   pitch_plus_tol;
  logic [CW+14:0]  qprod;
  logic [CW:0]     u_c;

  always_comb begin
    lat_abs = in_lat[CW-1] ? (~in_lat + 1'b1) : in_lat;
    within_c = 1'b1;
    if (in_ret[CW-1] || (in_ret > $signed({1'b0, lim_rl[CW-1:0]})))
      within_c = 1'b0;
    if (in_lift[CW-1] || (in_lift > $signed({1'b0, lim_rl[2*CW-1:CW]})))
      within_c = 1'b0;
    if (in_pitch[CW-1] || (in_pitch > $signed({1'b0, lim_pl[CW-1:0]})))
      within_c = 1'b0;
    if (lat_abs > lim_pl[2*CW-1:CW]) within_c = 1'b0;
    if (pivot && !free_motion && (in_lift != '0)) within_c = 1'b0;
    if (!pivot && (in_pitch != '0)) within_c = 1'b0;

    pitch_plus_tol = {{2{in_pitch[CW-1]}}, in_pitch} + {3'b000, pitch_tol};
    if (pivot) begin
      goal_c = !need_max ||
               ($signed(pitch_plus_tol) >= $signed({2'b00, lim_pl[CW-1:0]}));
    end else begin
      goal_c = !in_ret[CW-1] && !in_lift[CW-1] &&
               ({1'b0, in_ret[CW-2:0]} >= top_min[CW-1:0]) &&
               ({1'b0, in_lift[CW-2:0]} >= top_min[2*CW-1:CW]);
    end

    u_c   = {in_pitch[CW-1], in_pitch} + (CW+1)'(MOD_OFFSET);
    qprod = {14'd0, u_c} * (CW+15)'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      meta[1].ret       <= in_ret;
      meta[1].lift      <= in_lift;
      meta[1].in_bounds <= within_c;
      meta[1].goal_cond <= goal_c;
      u1                <= u_c;
      q1                <= qprod[37:32];
    end
  end

  for (genvar k = 2; k <= ST_MINMAX; k++) begin : g_meta
    always_ff @(posedge clk) begin
      if (en[k]) meta[k] <= meta[k-1];
    end
  end

  // stage 2: quotient times 2pi
  logic [CW:0] qd2;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      qd2 <= (CW+1)'(q1) * (CW+1)'(TWO_PI);
      u2  <= u1;
    end
  end

  // stage 3: remainder with one correction step
  logic [18:0] r3;
  logic [CW:0] rem_c;
  always_comb begin
    rem_c = u2 - qd2;
    if (rem_c >= (CW+1)'(TWO_PI)) rem_c = rem_c - (CW+1)'(TWO_PI);
  end
  always_ff @(posedge clk) begin
    if (en[3]) r3 <= rem_c[18:0];
  end

  // stage 4: fold into [-pi/2, pi/2], start cordic
  logic signed [ANG_W-1:0] cx [0:STAGES];
  logic signed [ANG_W-1:0] cy [0:STAGES];
  logic signed [ANG_W-1:0] cz [0:STAGES];
  logic                    cneg [0:STAGES];

  logic signed [19:0] rs_c, rf_c;
  logic               neg_c;
  always_comb begin
    rs_c = $signed({1'b0, r3});
    if (rs_c > 20'(PI_U)) rs_c = rs_c - 20'(TWO_PI);
    rf_c  = rs_c;
    neg_c = 1'b0;
    if (rs_c > 20'(HALF_PI)) begin
      rf_c  = rs_c - 20'(PI_U);
      neg_c = 1'b1;
    end else if (rs_c < -20'(HALF_PI)) begin
      rf_c  = rs_c + 20'(PI_U);
      neg_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_CORD0]) begin
      cx[0]   <= ANG_W'(GAIN_Q30);
      cy[0]   <= '0;
      cz[0]   <= ANG_W'(rf_c) <<< ANG_SHIFT;
      cneg[0] <= neg_c;
    end
  end

  // cordic rotation, one iteration per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en[ST_CORD0+1+i]) begin
        if (!cz[i][ANG_W-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_q30(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_q30(i);
        end
        cneg[i+1] <= cneg[i];
      end
    end
  end

  // sign fix for the folded half plane
  logic signed [ANG_W-1:0] cos_q, sin_q;
  always_ff @(posedge clk) begin
    if (en[ST_NEG]) begin
      cos_q <= cneg[STAGES] ? -cx[STAGES] : cx[STAGES];
      sin_q <= cneg[STAGES] ? -cy[STAGES] : cy[STAGES];
    end
  end

  // corner products
  logic signed [PW-1:0] p_cd, p_sd, p_ch, p_sh;
  logic signed [CW:0]   depth_s, height_s;
  assign depth_s  = $signed({1'b0, depth});
  assign height_s = $signed({1'b0, height});

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      p_cd <= PW'(cos_q) * PW'(depth_s);
      p_sd <= PW'(sin_q) * PW'(depth_s);
      p_ch <= PW'(cos_q) * PW'(height_s);
      p_sh <= PW'(sin_q) * PW'(height_s);
    end
  end

  // round half up back to length units
  function automatic logic signed [CRN_W-1:0] rnd30(input logic signed [PW:0] v);
    logic signed [PW:0] t;
    t = (v + (PW+1)'(64'sd1 <<< 29)) >>> 30;
    return t[CRN_W-1:0];
  endfunction

  logic signed [CRN_W-1:0] rx1, rz1, rx2, rz2, rx3, rz3;
  always_ff @(posedge clk) begin
    if (en[ST_RND]) begin
      rx1 <= rnd30(PW'(p_cd));
      rz1 <= rnd30(PW'(p_sd));
      rx2 <= rnd30((PW+1)'(p_cd) - (PW+1)'(p_sh));
      rz2 <= rnd30((PW+1)'(p_sd) + (PW+1)'(p_ch));
      rx3 <= rnd30(-(PW+1)'(p_sh));
      rz3 <= rnd30((PW+1)'(p_ch));
    end
  end

  // corner placement, translated in top mode, rotated in pivot mode
  logic signed [CRN_W-1:0] kx [0:3];
  logic signed [CRN_W-1:0] kz [0:3];
  logic signed [CRN_W-1:0] ret_e, lift_e, dep_e, hgt_e;
  assign ret_e  = CRN_W'(meta[ST_RND].ret);
  assign lift_e = CRN_W'(meta[ST_RND].lift);
  assign dep_e  = $signed({{(CRN_W-CW){1'b0}}, depth});
  assign hgt_e  = $signed({{(CRN_W-CW){1'b0}}, height});

  always_ff @(posedge clk) begin
    if (en[ST_CORNER]) begin
      kx[0] <= -ret_e;
      kz[0] <= lift_e;
      if (pivot) begin
        kx[1] <= rx1 - ret_e;
        kz[1] <= rz1 + lift_e;
        kx[2] <= rx2 - ret_e;
        kz[2] <= rz2 + lift_e;
        kx[3] <= rx3 - ret_e;
        kz[3] <= rz3 + lift_e;
      end else begin
        kx[1] <= dep_e - ret_e;
        kz[1] <= lift_e;
        kx[2] <= dep_e - ret_e;
        kz[2] <= hgt_e + lift_e;
        kx[3] <= -ret_e;
        kz[3] <= hgt_e + lift_e;
      end
    end
  end

  // bounding box
  logic signed [CRN_W-1:0] min_x, max_x, min_z, max_z;
  logic signed [CRN_W-1:0] mnx_c, mxx_c, mnz_c, mxz_c;
  always_comb begin
    mnx_c = kx[0];
    mxx_c = kx[0];
    mnz_c = kz[0];
    mxz_c = kz[0];
    for (int k = 1; k < 4; k++) begin
      if (kx[k] < mnx_c) mnx_c = kx[k];
      if (kx[k] > mxx_c) mxx_c = kx[k];
      if (kz[k] < mnz_c) mnz_c = kz[k];
      if (kz[k] > mxz_c) mxz_c = kz[k];
    end
  end
  always_ff @(posedge clk) begin
    if (en[ST_MINMAX]) begin
      min_x <= mnx_c;
      max_x <= mxx_c;
      min_z <= mnz_c;
      max_z <= mxz_c;
    end
  end

  // strict overlap against the grown source box, negative margin clamped
  logic signed [CRN_W-1:0] mg_e;
  logic                    overlap_c, detached_c;
  assign mg_e = margin[CW-1] ? '0 : $signed({{(CRN_W-CW){1'b0}}, margin});
  assign overlap_c = (min_x < dep_e + mg_e) && (max_x > -mg_e) &&
                     (min_z < hgt_e + mg_e) && (max_z > -mg_e);
  assign detached_c = !overlap_c;

  logic res_within, res_detached, res_goal;
  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      res_within   <= meta[ST_MINMAX].in_bounds;
      res_detached <= detached_c;
      res_goal     <= meta[ST_MINMAX].in_bounds && detached_c &&
                      meta[ST_MINMAX].goal_cond;
    end
  end

  assign m_tdata = {5'b00000, res_goal, res_detached, res_within};

endmodule

// ===== rtl/pbc_checker.sv =====
// ----------------------------------------------------------------------------
// pbc_checker
// port level checks of the pose check pipeline
// ----------------------------------------------------------------------------
`include "pose_bounds_collision_goal_check_macros.svh"

module pbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // no valid result right after reset
  `PBC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)

  // stalled result holds
  `PBC_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // goal only when in bounds and detached
  `PBC_ASSERT(a_goal, clk, rst, m_tvalid |-> !m_tdata[2] || (m_tdata[0] && m_tdata[1]))

  // input only backs up when the pipeline is full and the output stalls
  `PBC_ASSERT(a_backpressure, clk, rst, !s_tready |-> m_tvalid && !m_tready)

endmodule

bind pose_bounds_collision_goal_check pbc_checker u_pbc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
